>>> rtl/core/grid_bilinear_offset_interp_top_assert.svh
`ifndef GRID_BILINEAR_OFFSET_INTERP_TOP_ASSERT_SVH
`define GRID_BILINEAR_OFFSET_INTERP_TOP_ASSERT_SVH

// same-cycle implication, expects clk and arst_n in scope
`define GBOI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, expects clk and arst_n in scope
`define GBOI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gboi_pkg.sv
package gboi_pkg;

	localparam int DEF_GRID_COLS = 256;
	localparam int DEF_GRID_ROWS = 256;

	localparam int CFG_W     = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CELL_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NODATA_FLOOR = 3'd6;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_HOLE_X  = 2'd2;
	localparam logic [1:0] STAT_HOLE_Y  = 2'd3;

	localparam int MAC_A_W   = 50;
	localparam int MAC_B_W   = 17;
	localparam int MAC_ACC_W = 68;

	typedef enum logic [1:0] {
		MAC_NOP,
		MAC_CLR,
		MAC_ADD,
		MAC_SHADD
	} mac_op_t;

	typedef struct packed {
		logic               req_type;
		logic [7:0]         grid_row;
		logic [7:0]         grid_col;
		logic signed [31:0] cell_x_value;
		logic signed [31:0] cell_y_value;
		logic signed [39:0] point_x;
		logic signed [39:0] point_y;
		logic [15:0]        query_tag;
	} req_t;

	typedef struct packed {
		logic [15:0]        result_tag;
		logic [1:0]         status;
		logic signed [31:0] off_x;
		logic signed [31:0] off_y;
	} rsp_t;

endpackage

>>> rtl/core/gboi_ram.sv
module gboi_ram import gboi_pkg::*; #(
	parameter int DEPTH = DEF_GRID_ROWS * DEF_GRID_COLS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [CELL_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [CELL_W-1:0]        rdata
);

	logic [CELL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/gboi_mac.sv
module gboi_mac import gboi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mac_op_t                     op,
	input  logic signed [MAC_A_W-1:0]   a,
	input  logic [MAC_B_W-1:0]          b,
	output logic signed [MAC_ACC_W-1:0] acc
);

	logic signed [MAC_B_W:0]     b_s;
	logic signed [MAC_ACC_W-1:0] prod;
	logic signed [MAC_ACC_W-1:0] prod_s1;
	mac_op_t                     op_s1;
	logic signed [MAC_ACC_W-1:0] acc_q;

	assign b_s  = {1'b0, b};
	assign prod = a * b_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MAC_NOP;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		unique case (op_s1)
			MAC_CLR:   acc_q <= prod_s1;
			MAC_ADD:   acc_q <= acc_q + prod_s1;
			MAC_SHADD: acc_q <= (acc_q >>> 16) + prod_s1;
			default:   acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/grid_bilinear_offset_interp_top.sv
// A point outside the grid ends at the check after mapping, one with a hole corner at the
// first blend step, an interpolated answer after all blend steps; loads never raise busy.
// Queries run one at a time on one shared multiply-accumulate unit: 4 products map the
// point, 4 corner reads per grid, 12 products blend; a new word is taken in the strobe cycle.
// Reset clears the sequencer and sets the config registers to their defaults; grid cells
// hold no reset value. Done marks each result for one cycle only; the receiver cannot stall.
module grid_bilinear_offset_interp_top import gboi_pkg::*; #(
	parameter int GRID_COLS = DEF_GRID_COLS,
	parameter int GRID_ROWS = DEF_GRID_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output logic                 done,
	output rsp_t                 result
);

	localparam int CELLS   = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int ROW_W   = $clog2(GRID_ROWS);
	localparam int COL_W   = $clog2(GRID_COLS);
	localparam int POS_W   = 49;
	localparam int POS_LSB = 8;
	localparam int PART_W  = 49;
	localparam int STEP_W  = 4;

	localparam logic [STEP_W-1:0] MAP_LAST   = 4'd5;
	localparam logic [STEP_W-1:0] READ_LAST  = 4'd4;
	localparam logic [STEP_W-1:0] BLEND_LAST = 4'd13;

	localparam logic [31:0] GRID_COLS_U = 32'(GRID_COLS);

	localparam logic signed [MAC_ACC_W-1:0] RND_HALF =
		{{(MAC_ACC_W-32){1'b0}}, 32'h8000_0000};
	localparam logic signed [MAC_ACC_W-1:0] SAT_HI = {{(MAC_ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [MAC_ACC_W-1:0] SAT_LO = {{(MAC_ACC_W-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MAP   = 5'b00010,
		S_CHECK = 5'b00100,
		S_READ  = 5'b01000,
		S_BLEND = 5'b10000
	} fsm_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] r, input logic [31:0] c);
		return ADDR_W'(r * GRID_COLS_U + c);
	endfunction

	function automatic logic signed [MAC_A_W-1:0] ext_cell(input logic signed [CELL_W-1:0] v);
		return {{(MAC_A_W-CELL_W){v[CELL_W-1]}}, v};
	endfunction

	function automatic logic signed [MAC_A_W-1:0] ext_part(input logic signed [PART_W-1:0] v);
		return {{(MAC_A_W-PART_W){v[PART_W-1]}}, v};
	endfunction

	function automatic logic signed [31:0] round_sat(input logic signed [MAC_ACC_W-1:0] s);
		logic signed [MAC_ACC_W-1:0] r;
		r = (s + RND_HALF) >>> 32;
		if (r > SAT_HI) begin
			return 32'h7FFF_FFFF;
		end
		if (r < SAT_LO) begin
			return 32'h8000_0000;
		end
		return r[31:0];
	endfunction

	fsm_t              state_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	rsp_t              result_q;

	logic signed [39:0] origin_x_q, origin_y_q;
	logic [31:0]        inv_x_q, inv_y_q;
	logic [8:0]         cols_q, rows_q;
	logic signed [31:0] floor_q;

	logic [15:0]        tag_q;
	logic [39:0]        ud_x_q, ud_y_q;
	logic               rej_q;
	logic [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [15:0]        t_q, u_q;
	logic signed [CELL_W-1:0] cx_q [4];
	logic signed [CELL_W-1:0] cy_q [4];
	logic               hole_x_q, hole_y_q;
	logic signed [PART_W-1:0] ax_q, bx_q, ay_q, by_q;
	logic signed [31:0] off_x_q;

	logic signed [40:0] dx, dy;
	logic               neg_rej;
	logic               take_query, load_we, load_in_range;
	logic [32:0]        ix, iy, ncol, nrow;
	logic               outside;
	logic [1:0]         corner, cap_idx;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [CELL_W-1:0]  x_rdata, y_rdata;
	logic [MAC_B_W-1:0] t_b, t_w0, u_b, u_w0;

	mac_op_t                     mac_op;
	logic signed [MAC_A_W-1:0]   mac_a;
	logic [MAC_B_W-1:0]          mac_b;
	logic signed [MAC_ACC_W-1:0] acc;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign take_query    = start && !busy && (req.req_type == REQ_QUERY);
	assign load_in_range = (32'(req.grid_row) < 32'(GRID_ROWS)) &&
		(32'(req.grid_col) < 32'(GRID_COLS));
	assign load_we       = start && !busy && (req.req_type == REQ_LOAD) && load_in_range;
	assign wr_addr       = cell_addr(32'(req.grid_row), 32'(req.grid_col));

	assign dx = {req.point_x[39], req.point_x} - {origin_x_q[39], origin_x_q};
	assign dy = {req.point_y[39], req.point_y} - {origin_y_q[39], origin_y_q};
	assign neg_rej = (dx[40] && (inv_x_q != '0)) || (dy[40] && (inv_y_q != '0));

	assign ix   = pos_x_q[POS_W-1:16];
	assign iy   = pos_y_q[POS_W-1:16];
	assign ncol = (33'(cols_q) < 33'(GRID_COLS)) ? 33'(cols_q) : 33'(GRID_COLS);
	assign nrow = (33'(rows_q) < 33'(GRID_ROWS)) ? 33'(rows_q) : 33'(GRID_ROWS);
	assign outside = rej_q || (ncol < 33'd2) || (nrow < 33'd2) ||
		(ix > ncol - 33'd2) || (iy > nrow - 33'd2);

	assign corner  = step_q[1:0];
	assign cap_idx = step_q[1:0] - 2'd1;
	assign rd_addr = cell_addr(32'(row_q) + 32'(corner[1]), 32'(col_q) + 32'(corner[0]));

	assign t_b  = {1'b0, t_q};
	assign u_b  = {1'b0, u_q};
	assign t_w0 = {1'b1, 16'h0000} - t_b;
	assign u_w0 = {1'b1, 16'h0000} - u_b;

	gboi_ram #(
		.DEPTH (CELLS)
	) u_x_grid (
		.clk   (clk),
		.we    (load_we),
		.waddr (wr_addr),
		.wdata (req.cell_x_value),
		.raddr (rd_addr),
		.rdata (x_rdata)
	);

	gboi_ram #(
		.DEPTH (CELLS)
	) u_y_grid (
		.clk   (clk),
		.we    (load_we),
		.waddr (wr_addr),
		.wdata (req.cell_y_value),
		.raddr (rd_addr),
		.rdata (y_rdata)
	);

	gboi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	always_comb begin
		mac_op = MAC_NOP;
		mac_a  = '0;
		mac_b  = '0;
		unique case (state_q)
			S_MAP: begin
				unique case (step_q)
					4'd0: begin
						mac_op = MAC_CLR;
						mac_a  = {10'b0, ud_x_q};
						mac_b  = {1'b0, inv_x_q[15:0]};
					end
					4'd1: begin
						mac_op = MAC_SHADD;
						mac_a  = {10'b0, ud_x_q};
						mac_b  = {1'b0, inv_x_q[31:16]};
					end
					4'd2: begin
						mac_op = MAC_CLR;
						mac_a  = {10'b0, ud_y_q};
						mac_b  = {1'b0, inv_y_q[15:0]};
					end
					4'd3: begin
						mac_op = MAC_SHADD;
						mac_a  = {10'b0, ud_y_q};
						mac_b  = {1'b0, inv_y_q[31:16]};
					end
					default: ;
				endcase
			end
			S_BLEND: begin
				unique case (step_q)
					4'd0: begin
						mac_op = MAC_CLR;
						mac_a  = ext_cell(cx_q[0]);
						mac_b  = t_w0;
					end
					4'd1: begin
						mac_op = MAC_ADD;
						mac_a  = ext_cell(cx_q[1]);
						mac_b  = t_b;
					end
					4'd2: begin
						mac_op = MAC_CLR;
						mac_a  = ext_cell(cx_q[2]);
						mac_b  = t_w0;
					end
					4'd3: begin
						mac_op = MAC_ADD;
						mac_a  = ext_cell(cx_q[3]);
						mac_b  = t_b;
					end
					4'd4: begin
						mac_op = MAC_CLR;
						mac_a  = ext_cell(cy_q[0]);
						mac_b  = t_w0;
					end
					4'd5: begin
						mac_op = MAC_ADD;
						mac_a  = ext_cell(cy_q[1]);
						mac_b  = t_b;
					end
					4'd6: begin
						mac_op = MAC_CLR;
						mac_a  = ext_cell(cy_q[2]);
						mac_b  = t_w0;
					end
					4'd7: begin
						mac_op = MAC_ADD;
						mac_a  = ext_cell(cy_q[3]);
						mac_b  = t_b;
					end
					4'd8: begin
						mac_op = MAC_CLR;
						mac_a  = ext_part(ax_q);
						mac_b  = u_w0;
					end
					4'd9: begin
						mac_op = MAC_ADD;
						mac_a  = ext_part(bx_q);
						mac_b  = u_b;
					end
					4'd10: begin
						mac_op = MAC_CLR;
						mac_a  = ext_part(ay_q);
						mac_b  = u_w0;
					end
					4'd11: begin
						mac_op = MAC_ADD;
						mac_a  = ext_part(by_q);
						mac_b  = u_b;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_x_q    <= '0;
			inv_y_q    <= '0;
			cols_q     <= 9'd256;
			rows_q     <= 9'd256;
			floor_q    <= 32'sh8000_0000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ORIGIN_X:     origin_x_q <= cfg_wdata[39:0];
				CFG_ORIGIN_Y:     origin_y_q <= cfg_wdata[39:0];
				CFG_INV_CELL_X:   inv_x_q    <= cfg_wdata[31:0];
				CFG_INV_CELL_Y:   inv_y_q    <= cfg_wdata[31:0];
				CFG_COLS_IN_USE:  cols_q     <= cfg_wdata[8:0];
				CFG_ROWS_IN_USE:  rows_q     <= cfg_wdata[8:0];
				CFG_NODATA_FLOOR: floor_q    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take_query) begin
						state_q <= S_MAP;
						step_q  <= '0;
					end
				end
				S_MAP: begin
					if (step_q == MAP_LAST) begin
						state_q <= S_CHECK;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_CHECK: begin
					if (outside) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (step_q == READ_LAST) begin
						state_q <= S_BLEND;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_BLEND: begin
					if ((step_q == '0 && (hole_x_q || hole_y_q)) || step_q == BLEND_LAST) begin
						state_q <= S_IDLE;
						step_q  <= '0;
						done_q  <= 1'b1;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take_query) begin
					tag_q  <= req.query_tag;
					rej_q  <= neg_rej;
					ud_x_q <= dx[40] ? '0 : dx[39:0];
					ud_y_q <= dy[40] ? '0 : dy[39:0];
				end
			end
			S_MAP: begin
				if (step_q == 4'd3) begin
					pos_x_q <= acc[POS_LSB+POS_W-1:POS_LSB];
				end
				if (step_q == MAP_LAST) begin
					pos_y_q <= acc[POS_LSB+POS_W-1:POS_LSB];
				end
			end
			S_CHECK: begin
				row_q    <= iy[ROW_W-1:0];
				col_q    <= ix[COL_W-1:0];
				t_q      <= pos_x_q[15:0];
				u_q      <= pos_y_q[15:0];
				hole_x_q <= 1'b0;
				hole_y_q <= 1'b0;
				if (outside) begin
					result_q <= '{result_tag: tag_q, status: STAT_OUTSIDE, off_x: '0, off_y: '0};
				end
			end
			S_READ: begin
				if (step_q != '0) begin
					cx_q[cap_idx] <= x_rdata;
					cy_q[cap_idx] <= y_rdata;
					hole_x_q <= hole_x_q || ($signed(x_rdata) <= floor_q);
					hole_y_q <= hole_y_q || ($signed(y_rdata) <= floor_q);
				end
			end
			S_BLEND: begin
				unique case (step_q)
					4'd0: begin
						if (hole_x_q) begin
							result_q <= '{result_tag: tag_q, status: STAT_HOLE_X,
								off_x: '0, off_y: '0};
						end else if (hole_y_q) begin
							result_q <= '{result_tag: tag_q, status: STAT_HOLE_Y,
								off_x: '0, off_y: '0};
						end
					end
					4'd3:  ax_q <= acc[PART_W-1:0];
					4'd5:  bx_q <= acc[PART_W-1:0];
					4'd7:  ay_q <= acc[PART_W-1:0];
					4'd9:  by_q <= acc[PART_W-1:0];
					4'd11: off_x_q <= round_sat(acc);
					4'd13: begin
						result_q <= '{result_tag: tag_q, status: STAT_OK,
							off_x: off_x_q, off_y: round_sat(acc)};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/core/gboi_checker.sv
`include "grid_bilinear_offset_interp_top_assert.svh"

module gboi_checker import gboi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t result
);

	`GBOI_ASSERT_NEXT(a_done_single, done, !done, "done strobe held for two cycles")
	`GBOI_ASSERT_NEXT(a_query_busy, start && !busy && req.req_type == REQ_QUERY, busy, "query word did not raise busy")
	`GBOI_ASSERT_NEXT(a_load_idle, start && !busy && req.req_type == REQ_LOAD, !busy, "load word raised busy")
	`GBOI_ASSERT_NOW(a_done_after_busy, done, $past(busy), "done strobe without a query in flight")
	`GBOI_ASSERT_NOW(a_reject_zero, done && result.status != STAT_OK, result.off_x == '0 && result.off_y == '0, "rejected query carries nonzero offsets")

endmodule

bind grid_bilinear_offset_interp_top gboi_checker u_gboi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);
